[src/hpid_pkg.sv]
// ----------------------------------------------------------------------------
// hpid_pkg
// Shared widths, reset values, register codes and beat types for the heading
// PID controller with setpoint schedule.
// ----------------------------------------------------------------------------
`default_nettype none

package hpid_pkg;

    // Field and datapath widths.
    localparam int HEADING_W  = 15;
    localparam int ERR_W      = 16;
    localparam int DIFF_W     = 17;
    localparam int SUM_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int DWELL_W    = 10;
    localparam int IDX_W      = 2;
    localparam int DRIVE_W    = 13;
    localparam int NUM_SP     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Product and accumulation widths (Q.20).
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + SUM_W;
    localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;
    localparam int TOTAL_W  = PROD_I_W + 2;
    localparam int CLAMP_W  = 21;

    // Stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    // Drive limit of plus or minus 0.5 in Q.20, and the rounding bias to Q.12.
    localparam logic signed [TOTAL_W-1:0] DRIVE_MAX  = TOTAL_W'(524288);
    localparam logic signed [TOTAL_W-1:0] DRIVE_MIN  = -TOTAL_W'(524288);
    localparam logic signed [CLAMP_W-1:0] ROUND_BIAS = CLAMP_W'(128);

    // Saturation bounds of the error sum.
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SP0   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SP1   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SP2   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SP3   = 3'd7;

    // Register reset values.
    localparam logic [GAIN_W-1:0]    KP_RST    = 16'd1280;
    localparam logic [GAIN_W-1:0]    KI_RST    = 16'd26;
    localparam logic [GAIN_W-1:0]    KD_RST    = 16'd512;
    localparam logic [DWELL_W-1:0]   DWELL_RST = 10'd100;
    localparam logic [HEADING_W-1:0] SP0_RST   = 15'd715;
    localparam logic [HEADING_W-1:0] SP1_RST   = 15'd2145;
    localparam logic [HEADING_W-1:0] SP2_RST   = 15'd8579;
    localparam logic [HEADING_W-1:0] SP3_RST   = -15'sd8579;

    // Register file contents as seen by the datapath.
    typedef struct packed {
        logic [GAIN_W-1:0]                   kp;
        logic [GAIN_W-1:0]                   ki;
        logic [GAIN_W-1:0]                   kd;
        logic [DWELL_W-1:0]                  dwell;
        logic [NUM_SP-1:0][HEADING_W-1:0]    setpoint;
    } t_cfg;

    // Beat from the error stage to the control law stage.
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  sum;
        logic signed [DIFF_W-1:0] diff;
        logic [IDX_W-1:0]         idx;
    } t_err_beat;

endpackage

`default_nettype wire

[src/hpid_cfg.sv]
// ----------------------------------------------------------------------------
// hpid_cfg
// Configuration register file: gains, dwell count and the four setpoints.
// ----------------------------------------------------------------------------
`default_nettype none

module hpid_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [hpid_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [hpid_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output hpid_pkg::t_cfg                        o_cfg
);

    hpid_pkg::t_cfg r_cfg;

    // Registers load their reset values and take writes by index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp          <= hpid_pkg::KP_RST;
            r_cfg.ki          <= hpid_pkg::KI_RST;
            r_cfg.kd          <= hpid_pkg::KD_RST;
            r_cfg.dwell       <= hpid_pkg::DWELL_RST;
            r_cfg.setpoint[0] <= hpid_pkg::SP0_RST;
            r_cfg.setpoint[1] <= hpid_pkg::SP1_RST;
            r_cfg.setpoint[2] <= hpid_pkg::SP2_RST;
            r_cfg.setpoint[3] <= hpid_pkg::SP3_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hpid_pkg::CFG_KP:    r_cfg.kp    <= i_cfg_wdata;
                hpid_pkg::CFG_KI:    r_cfg.ki    <= i_cfg_wdata;
                hpid_pkg::CFG_KD:    r_cfg.kd    <= i_cfg_wdata;
                hpid_pkg::CFG_DWELL: r_cfg.dwell <= i_cfg_wdata[hpid_pkg::DWELL_W-1:0];
                hpid_pkg::CFG_SP0:   r_cfg.setpoint[0] <= i_cfg_wdata[hpid_pkg::HEADING_W-1:0];
                hpid_pkg::CFG_SP1:   r_cfg.setpoint[1] <= i_cfg_wdata[hpid_pkg::HEADING_W-1:0];
                hpid_pkg::CFG_SP2:   r_cfg.setpoint[2] <= i_cfg_wdata[hpid_pkg::HEADING_W-1:0];
                hpid_pkg::CFG_SP3:   r_cfg.setpoint[3] <= i_cfg_wdata[hpid_pkg::HEADING_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[src/hpid_err.sv]
// ----------------------------------------------------------------------------
// hpid_err
// Input register and error stage: picks the scheduled setpoint, forms the
// error, updates the saturating error sum, the previous error and the
// setpoint schedule, and registers the result for the control law stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hpid_err (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  hpid_pkg::t_cfg                        i_cfg,
    input  wire logic                             i_valid,
    input  wire logic [hpid_pkg::HEADING_W-1:0]   i_heading,
    output logic                                  o_ready,
    output logic                                  o_valid,
    output hpid_pkg::t_err_beat                   o_beat,
    input  wire logic                             i_ready
);

    // Input register.
    logic                              r_in_valid;
    logic [hpid_pkg::HEADING_W-1:0]    r_heading;

    // Controller state.
    logic signed [hpid_pkg::SUM_W-1:0] r_error_sum;
    logic signed [hpid_pkg::ERR_W-1:0] r_last_error;
    logic [hpid_pkg::DWELL_W-1:0]      r_tick_count;
    logic [hpid_pkg::IDX_W-1:0]        r_sched_idx;

    // Output register.
    logic                              r_out_valid;
    hpid_pkg::t_err_beat               r_beat;

    // Next values.
    logic                              out_free;
    logic                              fire;
    logic [hpid_pkg::HEADING_W-1:0]    target;
    logic signed [hpid_pkg::ERR_W-1:0] n_err;
    logic signed [hpid_pkg::SUM_W:0]   sum_wide;
    logic signed [hpid_pkg::SUM_W-1:0] n_error_sum;
    logic signed [hpid_pkg::DIFF_W-1:0] n_diff;
    logic [hpid_pkg::DWELL_W:0]        tick_inc;
    logic                              wrap;
    logic [hpid_pkg::DWELL_W-1:0]      n_tick_count;
    logic [hpid_pkg::IDX_W-1:0]        n_sched_idx;

    // Handshake: each register moves on when the one after it is free.
    assign out_free = !r_out_valid || i_ready;
    assign fire     = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    // Error, saturating sum, difference and schedule step.
    always_comb begin
        target   = i_cfg.setpoint[r_sched_idx];
        n_err    = {target[hpid_pkg::HEADING_W-1], target}
                 - {r_heading[hpid_pkg::HEADING_W-1], r_heading};
        sum_wide = {r_error_sum[hpid_pkg::SUM_W-1], r_error_sum}
                 + {{(hpid_pkg::SUM_W+1-hpid_pkg::ERR_W){n_err[hpid_pkg::ERR_W-1]}}, n_err};
        if (sum_wide[hpid_pkg::SUM_W] != sum_wide[hpid_pkg::SUM_W-1]) begin
            n_error_sum = sum_wide[hpid_pkg::SUM_W] ? hpid_pkg::SUM_MIN : hpid_pkg::SUM_MAX;
        end else begin
            n_error_sum = sum_wide[hpid_pkg::SUM_W-1:0];
        end
        n_diff = {n_err[hpid_pkg::ERR_W-1], n_err}
               - {r_last_error[hpid_pkg::ERR_W-1], r_last_error};
        tick_inc = {1'b0, r_tick_count} + (hpid_pkg::DWELL_W+1)'(1);
        wrap     = tick_inc >= {1'b0, i_cfg.dwell};
        if (wrap) begin
            n_tick_count = '0;
            n_sched_idx  = r_sched_idx + hpid_pkg::IDX_W'(1);
        end else begin
            n_tick_count = tick_inc[hpid_pkg::DWELL_W-1:0];
            n_sched_idx  = r_sched_idx;
        end
    end

    // Control state and valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_error_sum  <= '0;
            r_last_error <= '0;
            r_tick_count <= '0;
            r_sched_idx  <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_error_sum  <= n_error_sum;
                r_last_error <= n_err;
                r_tick_count <= n_tick_count;
                r_sched_idx  <= n_sched_idx;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_heading <= i_heading;
        end
        if (fire) begin
            r_beat.err  <= n_err;
            r_beat.sum  <= n_error_sum;
            r_beat.diff <= n_diff;
            r_beat.idx  <= r_sched_idx;
        end
    end

    assign o_valid = r_out_valid;
    assign o_beat  = r_beat;

    // State moves only when a beat passes through the error stage.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !fire) |=> ($stable(r_error_sum) && $stable(r_last_error)
                                && $stable(r_tick_count) && $stable(r_sched_idx)))
        else $error("controller state changed without a beat");

    // The schedule steps by exactly one when the dwell count runs out.
    a_sched_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && fire && wrap) |=> (r_sched_idx == $past(r_sched_idx) + 2'd1
                                       && r_tick_count == '0))
        else $error("setpoint schedule did not advance");

    // A beat waiting in the input register is kept while the output is blocked.
    a_in_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_in_valid && !out_free) |=> r_in_valid)
        else $error("error stage dropped a beat");

endmodule

`default_nettype wire

[src/hpid_law.sv]
// ----------------------------------------------------------------------------
// hpid_law
// Control law stage: registers the three gain products, then sums them,
// clamps the total to plus or minus 0.5 and rounds it to Q.12 into the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hpid_law (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  hpid_pkg::t_cfg                        i_cfg,
    input  wire logic                             i_valid,
    input  hpid_pkg::t_err_beat                   i_beat,
    output logic                                  o_ready,
    output logic                                  o_valid,
    output logic [hpid_pkg::DRIVE_W-1:0]          o_drive,
    output logic [hpid_pkg::ERR_W-1:0]            o_heading_error,
    output logic [hpid_pkg::IDX_W-1:0]            o_target_index,
    input  wire logic                             i_ready
);

    // Product register.
    logic                                  r_prod_valid;
    logic signed [hpid_pkg::PROD_P_W-1:0]  r_prod_p;
    logic signed [hpid_pkg::PROD_I_W-1:0]  r_prod_i;
    logic signed [hpid_pkg::PROD_D_W-1:0]  r_prod_d;
    logic signed [hpid_pkg::ERR_W-1:0]     r_prod_err;
    logic [hpid_pkg::IDX_W-1:0]            r_prod_idx;

    // Output register.
    logic                                  r_out_valid;
    logic signed [hpid_pkg::DRIVE_W-1:0]   r_drive;
    logic [hpid_pkg::ERR_W-1:0]            r_err;
    logic [hpid_pkg::IDX_W-1:0]            r_idx;

    logic                                  out_free;
    logic signed [hpid_pkg::GAIN_W:0]      kp_s;
    logic signed [hpid_pkg::GAIN_W:0]      ki_s;
    logic signed [hpid_pkg::GAIN_W:0]      kd_s;
    logic signed [hpid_pkg::PROD_P_W-1:0]  n_prod_p;
    logic signed [hpid_pkg::PROD_I_W-1:0]  n_prod_i;
    logic signed [hpid_pkg::PROD_D_W-1:0]  n_prod_d;
    logic signed [hpid_pkg::TOTAL_W-1:0]   total;
    logic signed [hpid_pkg::TOTAL_W-1:0]   clamped;
    logic signed [hpid_pkg::CLAMP_W-1:0]   rounded;
    logic signed [hpid_pkg::DRIVE_W-1:0]   n_drive;

    // Handshake.
    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = !r_prod_valid || out_free;

    // Gain products in Q.20; unsigned gains get a zero sign bit.
    always_comb begin
        kp_s     = {1'b0, i_cfg.kp};
        ki_s     = {1'b0, i_cfg.ki};
        kd_s     = {1'b0, i_cfg.kd};
        n_prod_p = kp_s * i_beat.err;
        n_prod_i = ki_s * i_beat.sum;
        n_prod_d = kd_s * i_beat.diff;
    end

    // Sum, clamp, and round half upward to Q.12 (floor of the biased value).
    always_comb begin
        total = hpid_pkg::TOTAL_W'(r_prod_p) + hpid_pkg::TOTAL_W'(r_prod_i)
              + hpid_pkg::TOTAL_W'(r_prod_d);
        if (total > hpid_pkg::DRIVE_MAX) begin
            clamped = hpid_pkg::DRIVE_MAX;
        end else if (total < hpid_pkg::DRIVE_MIN) begin
            clamped = hpid_pkg::DRIVE_MIN;
        end else begin
            clamped = total;
        end
        rounded = clamped[hpid_pkg::CLAMP_W-1:0] + hpid_pkg::ROUND_BIAS;
        n_drive = rounded[hpid_pkg::CLAMP_W-1:hpid_pkg::CLAMP_W-hpid_pkg::DRIVE_W];
    end

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_prod_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_prod_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod_p   <= n_prod_p;
            r_prod_i   <= n_prod_i;
            r_prod_d   <= n_prod_d;
            r_prod_err <= i_beat.err;
            r_prod_idx <= i_beat.idx;
        end
        if (out_free && r_prod_valid) begin
            r_drive <= n_drive;
            r_err   <= r_prod_err;
            r_idx   <= r_prod_idx;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_drive         = r_drive;
    assign o_heading_error = r_err;
    assign o_target_index  = r_idx;

    // A delivered drive never exceeds the clamp.
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_drive <= 13'sd2048 && r_drive >= -13'sd2048))
        else $error("drive outside the clamp range");

    // A product beat is kept while the output register is blocked.
    a_prod_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_prod_valid && !out_free) |=> (r_prod_valid && $stable(r_prod_err)))
        else $error("control law stage dropped a beat");

endmodule

`default_nettype wire

[src/heading_pid_with_setpoint_schedule.sv]
// ----------------------------------------------------------------------------
// heading_pid_with_setpoint_schedule
// Heading PID controller with a four-entry setpoint schedule and a clamped
// drive output.
// ----------------------------------------------------------------------------
// Each input beat carries one measured heading; each produces exactly one
// output beat with the clamped drive, the heading error and the index of the
// setpoint used. The block takes one beat per clock cycle while the output
// is not stalled, and a result passes through the input register, error
// stage, product register and output register. The rate is set by the error
// stage, where the error sum, previous error and schedule count update once
// per beat. Output stalls hold results in place while earlier stages with
// room keep accepting. Write configuration only when no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module heading_pid_with_setpoint_schedule (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port.
    input  wire logic                              i_cfg_we,
    input  wire logic [hpid_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [hpid_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // Heading input stream.
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [14:0] heading, [15] zero
    input  wire logic [hpid_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // Result output stream.
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [12:0] drive, [28:13] heading_error, [30:29] target_index, [31] zero
    output logic [hpid_pkg::M_TDATA_W-1:0]         m_axis_tdata
);

    hpid_pkg::t_cfg       cfg;
    hpid_pkg::t_err_beat  err_beat;
    logic                 err_valid;
    logic                 law_ready;
    logic [hpid_pkg::DRIVE_W-1:0] drive;
    logic [hpid_pkg::ERR_W-1:0]   heading_error;
    logic [hpid_pkg::IDX_W-1:0]   target_index;

    // Configuration registers.
    hpid_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Error and state stage.
    hpid_err u_err (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (s_axis_tvalid),
        .i_heading (s_axis_tdata[hpid_pkg::HEADING_W-1:0]),
        .o_ready   (s_axis_tready),
        .o_valid   (err_valid),
        .o_beat    (err_beat),
        .i_ready   (law_ready)
    );

    // Control law stage.
    hpid_law u_law (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (err_valid),
        .i_beat          (err_beat),
        .o_ready         (law_ready),
        .o_valid         (m_axis_tvalid),
        .o_drive         (drive),
        .o_heading_error (heading_error),
        .o_target_index  (target_index),
        .i_ready         (m_axis_tready)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {1'b0, target_index, heading_error, drive};

endmodule

`default_nettype wire
